// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the response matcher.
// No dependencies; the assertions compile out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define PFRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PFRM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define PFRM_ASSERT(lbl, prop, msg)
`define PFRM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- rtl/pfrm_pkg.sv -----
// Package for the pass/fail response matcher: command, verdict and register codes,
// field widths, register reset values and string-match helpers. No dependencies.
package pfrm_pkg;

    localparam int unsigned MAX_PATTERN = 8;
    localparam int unsigned CNT_W       = 4;
    localparam int unsigned TICK_W      = 24;
    localparam int unsigned PAT_W       = 64;
    localparam int unsigned CFG_ADDR_W  = 3;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        VERDICT_PASS    = 2'd0,
        VERDICT_FAIL    = 2'd1,
        VERDICT_TIMEOUT = 2'd2
    } t_verdict;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PASS_PATTERN  = 3'd0,
        REG_PASS_LENGTH   = 3'd1,
        REG_FAIL_PATTERN  = 3'd2,
        REG_FAIL_LENGTH   = 3'd3,
        REG_FAIL_ENABLE   = 3'd4,
        REG_TIMEOUT_LIMIT = 3'd5
    } t_reg_idx;

    localparam logic [PAT_W-1:0]  RST_PASS_PATTERN  = 64'd19279;
    localparam logic [CNT_W-1:0]  RST_PASS_LENGTH   = 4'd2;
    localparam logic [PAT_W-1:0]  RST_FAIL_PATTERN  = 64'd353518113349;
    localparam logic [CNT_W-1:0]  RST_FAIL_LENGTH   = 4'd5;
    localparam logic              RST_FAIL_ENABLE   = 1'b1;
    localparam logic [TICK_W-1:0] RST_TIMEOUT_LIMIT = 24'd1000;

    // Step result of one string matcher
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             done;
    } t_match;

    // A length of zero counts as one, lengths above MAX_PATTERN are clamped.
    function automatic logic [CNT_W-1:0] eff_length(input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] res;
        if (len == '0) begin
            res = CNT_W'(1);
        end else if (len > CNT_W'(MAX_PATTERN)) begin
            res = CNT_W'(MAX_PATTERN);
        end else begin
            res = len;
        end
        return res;
    endfunction

    // Advance a match count with one byte. A mismatch drops the count to zero
    // without comparing the byte against the first character again.
    function automatic t_match advance(input logic [CNT_W-1:0] count,
                                       input logic [PAT_W-1:0] pattern,
                                       input logic [CNT_W-1:0] len_reg,
                                       input logic [7:0]       rx);
        logic [CNT_W-1:0] len;
        logic [CNT_W-1:0] idx;
        logic [7:0]       ch;
        t_match           res;
        len = eff_length(len_reg);
        idx = (count >= len) ? '0 : count;
        ch  = pattern[{idx[2:0], 3'b000} +: 8];
        if (rx == ch) begin
            res.count = idx + CNT_W'(1);
            res.done  = (res.count == len);
        end else begin
            res.count = '0;
            res.done  = 1'b0;
        end
        return res;
    endfunction

endpackage

// ----- rtl/pass_fail_response_matcher.sv -----
// Pass/fail response matcher, top level.
// Depends on pfrm_pkg and assert_macros.svh.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries one word: i_cmd and
//    i_rx_byte. START opens a match and clears both string counts and the
//    elapsed tick count; BYTE feeds one received character; TICK counts one
//    millisecond. Command code 3 is dropped without a result.
//  - Output channel (o_out_valid / i_out_ready) carries at most one verdict
//    word per input word: PASS, FAIL or TIMEOUT. After a verdict the matcher
//    goes inactive and ignores bytes and ticks until the next START. A START
//    with a zero timeout limit answers TIMEOUT at once.
//  - Registers are written through i_cfg_we / i_cfg_addr / i_cfg_data by the user
//    only while no word is in flight (not enforced). Unused indexes are dropped.
//  - Path: an accepted word is held in the input register and evaluated there;
//    its verdict is written into the verdict register.
//  - Throughput: one word per cycle when not stalled; the string compare and tick
//    update are a single pass of logic between the input and verdict registers.
//  - Stall: the verdict register holds while i_out_ready is low; the input
//    register still takes one more word, and a word that gives no verdict
//    passes through even with a verdict waiting.
//  - Reset (synchronous, i_rst_n low): matcher inactive, counts zero, both
//    registers empty, configuration back to its defaults.
module pass_fail_response_matcher (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input words
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_cmd,
    input  logic [7:0]                          i_rx_byte,
    // verdict words
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_verdict,
    // register writes
    input  logic                                i_cfg_we,
    input  logic [pfrm_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [pfrm_pkg::PAT_W-1:0]          i_cfg_data
);
    import pfrm_pkg::*;

    `include "assert_macros.svh"

    // Configuration registers
    logic [PAT_W-1:0]  r_pass_pattern;
    logic [CNT_W-1:0]  r_pass_length;
    logic [PAT_W-1:0]  r_fail_pattern;
    logic [CNT_W-1:0]  r_fail_length;
    logic              r_fail_enable;
    logic [TICK_W-1:0] r_timeout_limit;

    // Match state
    logic              r_active,  n_active;
    logic [CNT_W-1:0]  r_pass_count, n_pass_count;
    logic [CNT_W-1:0]  r_fail_count, n_fail_count;
    logic [TICK_W-1:0] r_elapsed, n_elapsed;

    // Input register
    logic              r_in_valid;
    t_cmd              r_cmd;
    logic [7:0]        r_rx_byte;

    // Verdict register
    logic              r_out_valid;
    t_verdict          r_verdict;

    // Evaluation of the held word
    t_match            pass_m;
    t_match            fail_m;
    logic [TICK_W-1:0] tick_next;
    logic              produce;
    t_verdict          verdict;
    logic              proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_pattern  <= RST_PASS_PATTERN;
            r_pass_length   <= RST_PASS_LENGTH;
            r_fail_pattern  <= RST_FAIL_PATTERN;
            r_fail_length   <= RST_FAIL_LENGTH;
            r_fail_enable   <= RST_FAIL_ENABLE;
            r_timeout_limit <= RST_TIMEOUT_LIMIT;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_PASS_PATTERN:  r_pass_pattern  <= i_cfg_data;
                REG_PASS_LENGTH:   r_pass_length   <= i_cfg_data[CNT_W-1:0];
                REG_FAIL_PATTERN:  r_fail_pattern  <= i_cfg_data;
                REG_FAIL_LENGTH:   r_fail_length   <= i_cfg_data[CNT_W-1:0];
                REG_FAIL_ENABLE:   r_fail_enable   <= i_cfg_data[0];
                REG_TIMEOUT_LIMIT: r_timeout_limit <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    assign pass_m    = advance(r_pass_count, r_pass_pattern, r_pass_length, r_rx_byte);
    assign fail_m    = advance(r_fail_count, r_fail_pattern, r_fail_length, r_rx_byte);
    assign tick_next = (r_elapsed == TICK_MAX) ? r_elapsed : r_elapsed + TICK_W'(1);

    // Next match state and verdict for the held word
    always_comb begin
        n_active     = r_active;
        n_pass_count = r_pass_count;
        n_fail_count = r_fail_count;
        n_elapsed    = r_elapsed;
        produce      = 1'b0;
        verdict      = VERDICT_TIMEOUT;
        case (r_cmd)
            CMD_START: begin
                n_pass_count = '0;
                n_fail_count = '0;
                n_elapsed    = '0;
                if (r_timeout_limit == '0) begin
                    n_active = 1'b0;
                    produce  = 1'b1;
                end else begin
                    n_active = 1'b1;
                end
            end
            CMD_BYTE: begin
                if (r_active) begin
                    // pass string has priority; fail count untouched on a pass
                    n_pass_count = pass_m.count;
                    if (pass_m.done) begin
                        n_active = 1'b0;
                        produce  = 1'b1;
                        verdict  = VERDICT_PASS;
                    end else if (r_fail_enable) begin
                        n_fail_count = fail_m.count;
                        if (fail_m.done) begin
                            n_active = 1'b0;
                            produce  = 1'b1;
                            verdict  = VERDICT_FAIL;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (r_active) begin
                    n_elapsed = tick_next;
                    if (tick_next >= r_timeout_limit) begin
                        n_active = 1'b0;
                        produce  = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Held word moves on unless it makes a verdict and the verdict slot is full and stalled
    assign proc       = r_in_valid && (!produce || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_active     <= 1'b0;
            r_pass_count <= '0;
            r_fail_count <= '0;
            r_elapsed    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                r_active     <= n_active;
                r_pass_count <= n_pass_count;
                r_fail_count <= n_fail_count;
                r_elapsed    <= n_elapsed;
            end
            if (proc && produce) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd     <= t_cmd'(i_cmd);
            r_rx_byte <= i_rx_byte;
        end
        if (proc && produce) begin
            r_verdict <= verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

    `PFRM_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !r_active && !r_in_valid && !r_out_valid, "reset left matcher busy")
    `PFRM_ASSERT(a_verdict_closes, proc && produce |=> !r_active, "verdict did not close the match")
    `PFRM_ASSERT(a_count_bound, r_pass_count <= CNT_W'(MAX_PATTERN) && r_fail_count <= CNT_W'(MAX_PATTERN), "match count beyond pattern size")
    `PFRM_ASSERT(a_out_hold, r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_verdict), "stalled verdict overwritten")
    `PFRM_ASSERT(a_in_hold, r_in_valid && !proc |=> r_in_valid && $stable(r_cmd) && $stable(r_rx_byte), "held input word lost")

endmodule

// ----- tb/pass_fail_response_matcher_tb.sv -----
// Self-checking testbench for pass_fail_response_matcher: directed and random words
// checked against a predictor of the matcher. Depends on pfrm_pkg and the matcher RTL.
module pass_fail_response_matcher_tb;

    import pfrm_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RST_CYCLES   = 6;
    // cycles with no word moving on either channel before the run is abandoned
    localparam int QUIET_LIMIT  = 4000;
    // long receiver hold-off used to back the matcher up
    localparam int HOLD_CYCLES  = 250;
    localparam int RANDOM_WORDS = 1900;
    // random words between two reconfigurations
    localparam int CFG_SPAN     = 60;
    localparam int MAX_REPORTS  = 10;
    // idle cycles let pass after the last verdict, for words that give no verdict
    localparam int SETTLE_CYCLES = 4;

    // command code with no meaning; the matcher drops it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [1:0]            i_cmd;
    logic [7:0]            i_rx_byte;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_verdict;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [PAT_W-1:0]      i_cfg_data;

    pass_fail_response_matcher i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_verdict   (o_verdict),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor state: shadow registers and the matcher's own state
    // ------------------------------------------------------------------
    logic [PAT_W-1:0]  m_pass_pat;
    logic [CNT_W-1:0]  m_pass_len;
    logic [PAT_W-1:0]  m_fail_pat;
    logic [CNT_W-1:0]  m_fail_len;
    logic              m_fail_en;
    logic [TICK_W-1:0] m_limit;

    logic              m_active;
    logic [CNT_W-1:0]  m_pass_cnt;
    logic [CNT_W-1:0]  m_fail_cnt;
    logic [TICK_W-1:0] m_ticks;

    // verdicts predicted but not yet seen on the output channel
    t_verdict          verdict_q[$];
    logic [1:0]        want_verdict;
    int                err_count;

    // idle rates in percent, sender and receiver
    int                tx_idle_pct;
    int                rx_idle_pct;
    // long hold-off request to the receiver process, and what is left of it
    bit                hold_req;
    int                hold_left;
    int                quiet_cycles;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Lengths of zero act as one, lengths past the pattern store act as its size.
    function automatic logic [CNT_W-1:0] clamp_len(input logic [CNT_W-1:0] len);
        if (len == '0) begin
            return CNT_W'(1);
        end
        if (len > CNT_W'(MAX_PATTERN)) begin
            return CNT_W'(MAX_PATTERN);
        end
        return len;
    endfunction

    // Position the next byte is compared at; a stale count past the length restarts.
    function automatic logic [CNT_W-1:0] match_pos(input logic [CNT_W-1:0] cnt,
                                                   input logic [CNT_W-1:0] len_reg);
        return (cnt >= clamp_len(len_reg)) ? '0 : cnt;
    endfunction

    function automatic logic [7:0] char_at(input logic [PAT_W-1:0] pat,
                                           input logic [CNT_W-1:0] pos);
        return 8'(pat >> (8 * pos[2:0]));
    endfunction

    // One byte against one string; a miss drops the count without a second look
    // at the first character. Returns 1 when the string is complete.
    function automatic bit string_hit(inout logic [CNT_W-1:0] cnt,
                                      input logic [PAT_W-1:0] pat,
                                      input logic [CNT_W-1:0] len_reg,
                                      input logic [7:0]       rx);
        logic [CNT_W-1:0] pos;
        pos = match_pos(cnt, len_reg);
        if (rx == char_at(pat, pos)) begin
            cnt = pos + CNT_W'(1);
            return cnt == clamp_len(len_reg);
        end
        cnt = '0;
        return 1'b0;
    endfunction

    // Update the predicted state with one accepted word, queue its verdict if any.
    task automatic predict_word(input logic [1:0] cmd, input logic [7:0] rx);
        case (cmd)
            CMD_START: begin
                m_pass_cnt = '0;
                m_fail_cnt = '0;
                m_ticks    = '0;
                if (m_limit == '0) begin
                    // zero limit: timeout at once, match stays closed
                    m_active = 1'b0;
                    verdict_q.push_back(VERDICT_TIMEOUT);
                end else begin
                    m_active = 1'b1;
                end
            end
            CMD_BYTE: begin
                if (m_active) begin
                    // pass string has priority over the fail string
                    if (string_hit(m_pass_cnt, m_pass_pat, m_pass_len, rx)) begin
                        m_active = 1'b0;
                        verdict_q.push_back(VERDICT_PASS);
                    end else if (m_fail_en) begin
                        if (string_hit(m_fail_cnt, m_fail_pat, m_fail_len, rx)) begin
                            m_active = 1'b0;
                            verdict_q.push_back(VERDICT_FAIL);
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (m_active) begin
                    if (m_ticks != TICK_MAX) begin
                        m_ticks = m_ticks + TICK_W'(1);
                    end
                    if (m_ticks >= m_limit) begin
                        m_active = 1'b0;
                        verdict_q.push_back(VERDICT_TIMEOUT);
                    end
                end
            end
            default: begin
                // unused code, no effect
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one word. Entered at a falling edge; returns at the falling edge after
    // acceptance with valid still high, so a following word can go out back to back.
    task automatic send_word(input logic [1:0] cmd, input logic [7:0] rx);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_cmd      = cmd;
        i_rx_byte  = rx;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        predict_word(cmd, rx);
        @(negedge i_clk);
    endtask

    // Stop offering words and wait until every predicted verdict has come out,
    // then idle on for words that give no verdict.
    task automatic drain_verdicts();
        i_in_valid = 1'b0;
        while (verdict_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One register write; only called with the matcher drained.
    task automatic write_reg(input t_reg_idx idx, input logic [PAT_W-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = val;
        case (idx)
            REG_PASS_PATTERN:  m_pass_pat = val;
            REG_PASS_LENGTH:   m_pass_len = val[CNT_W-1:0];
            REG_FAIL_PATTERN:  m_fail_pat = val;
            REG_FAIL_LENGTH:   m_fail_len = val[CNT_W-1:0];
            REG_FAIL_ENABLE:   m_fail_en  = val[0];
            REG_TIMEOUT_LIMIT: m_limit    = val[TICK_W-1:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Output side: ready pattern and verdict check
    // ------------------------------------------------------------------
    initial begin
        i_out_ready = 1'b0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                i_out_ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Every verdict word is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (verdict_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS) begin
                    $display("verdict %0d with none predicted", o_verdict);
                end
            end else begin
                want_verdict = verdict_q.pop_front();
                if (o_verdict !== want_verdict) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("verdict mismatch: expected %0d, got %0d",
                                 want_verdict, o_verdict);
                    end
                end
            end
        end
    end

    // Watchdog: ends a run that stops moving words on both channels.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults ("OK" / "ERROR"): bytes, ticks and the unused code are
    // ignored before the first start and again after a verdict.
    task automatic test_idle_until_start();
        send_word(CMD_BYTE, 8'h4F);
        send_word(CMD_TICK, 8'h00);
        send_word(CMD_UNUSED, 8'hFF);
        send_word(CMD_START, 8'hA5);
        send_word(CMD_BYTE, 8'h4F);
        send_word(CMD_BYTE, 8'h4B);
        send_word(CMD_BYTE, 8'h4B);
        drain_verdicts();
    endtask

    task automatic test_fail_string();
        send_word(CMD_START, 8'h00);
        send_word(CMD_BYTE, 8'h45);
        send_word(CMD_BYTE, 8'h52);
        send_word(CMD_BYTE, 8'h52);
        send_word(CMD_BYTE, 8'h4F);
        send_word(CMD_BYTE, 8'h52);
        drain_verdicts();
    endtask

    // A start with no time allowed times out by itself; a limit of one needs one tick.
    task automatic test_zero_timeout();
        write_reg(REG_TIMEOUT_LIMIT, '0);
        send_word(CMD_START, 8'h00);
        send_word(CMD_TICK, 8'h00);
        drain_verdicts();
        write_reg(REG_TIMEOUT_LIMIT, 64'd1);
        send_word(CMD_START, 8'h00);
        send_word(CMD_TICK, 8'h00);
        drain_verdicts();
    endtask

    // Both strings complete on the same byte (zero lengths act as one): pass wins.
    task automatic test_pass_priority();
        write_reg(REG_PASS_PATTERN, '0);
        write_reg(REG_PASS_LENGTH, '0);
        write_reg(REG_FAIL_PATTERN, '0);
        write_reg(REG_FAIL_LENGTH, '0);
        write_reg(REG_TIMEOUT_LIMIT, 64'd1000);
        send_word(CMD_START, 8'h00);
        send_word(CMD_BYTE, 8'h00);
        drain_verdicts();
    endtask

    // Length above the store is clamped; lowering it mid-match leaves a count
    // past the new length, which restarts the compare at the first character.
    task automatic test_length_lowered();
        write_reg(REG_PASS_PATTERN, '1);
        write_reg(REG_PASS_LENGTH, 64'd15);
        write_reg(REG_FAIL_ENABLE, '0);
        send_word(CMD_START, 8'h00);
        repeat (5) send_word(CMD_BYTE, 8'hFF);
        drain_verdicts();
        write_reg(REG_PASS_LENGTH, 64'd3);
        repeat (3) send_word(CMD_BYTE, 8'hFF);
        drain_verdicts();
    endtask

    // Limit dropped below the elapsed count: the next tick times out.
    task automatic test_limit_lowered();
        write_reg(REG_TIMEOUT_LIMIT, 64'd100);
        send_word(CMD_START, 8'h00);
        repeat (3) send_word(CMD_TICK, 8'h00);
        drain_verdicts();
        write_reg(REG_TIMEOUT_LIMIT, 64'd2);
        send_word(CMD_TICK, 8'h00);
        drain_verdicts();
    endtask

    // Receiver holds off for a long stretch while every word gives a verdict,
    // so the matcher fills and must stall its input.
    task automatic test_output_backpressure();
        write_reg(REG_TIMEOUT_LIMIT, '0);
        hold_req = 1'b1;
        repeat (24) send_word(CMD_START, 8'($urandom_range(255)));
        drain_verdicts();
    endtask

    // New random register set; extremes turn up now and then, upper data bits
    // of the narrow registers are random to check that they are dropped.
    task automatic random_setup();
        logic [PAT_W-1:0] pass_pat;
        logic [PAT_W-1:0] fail_pat;
        logic [PAT_W-1:0] data;
        logic [CNT_W-1:0] len;
        int               pick;

        pick = $urandom_range(9);
        pass_pat = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
        pick = $urandom_range(9);
        fail_pat = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
        // shared first character so both strings chase the same bytes
        if ($urandom_range(3) == 0) begin
            fail_pat[7:0] = pass_pat[7:0];
        end
        write_reg(REG_PASS_PATTERN, pass_pat);
        write_reg(REG_FAIL_PATTERN, fail_pat);

        for (int i = 0; i < 2; i++) begin
            pick = $urandom_range(19);
            if (pick == 0) begin
                len = '0;
            end else if (pick == 1) begin
                len = '1;
            end else if (pick == 2) begin
                len = CNT_W'($urandom_range(9, 15));
            end else begin
                len = CNT_W'($urandom_range(1, MAX_PATTERN));
            end
            data = {$urandom, $urandom};
            data[CNT_W-1:0] = len;
            write_reg((i == 0) ? REG_PASS_LENGTH : REG_FAIL_LENGTH, data);
        end

        data = {$urandom, $urandom};
        write_reg(REG_FAIL_ENABLE, data);

        data = {$urandom, $urandom};
        pick = $urandom_range(19);
        if (pick == 0) begin
            data[TICK_W-1:0] = '0;
        end else if (pick == 1) begin
            data[TICK_W-1:0] = TICK_MAX;
        end else if (pick == 2) begin
            data[TICK_W-1:0] = TICK_W'($urandom_range(1000, 100000));
        end else begin
            data[TICK_W-1:0] = TICK_W'($urandom_range(1, 40));
        end
        write_reg(REG_TIMEOUT_LIMIT, data);
    endtask

    // Random matches. Each start picks a target (pass string, fail string or
    // noise) and most bytes follow that string from the predicted count, so
    // long strings do complete; ticks, stray bytes and restarts break in.
    task automatic test_random_traffic();
        int         words;
        int         since_cfg;
        int         pick;
        logic [1:0] target;
        logic [7:0] rx;

        target = 2'd0;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin tx_idle_pct = 14; rx_idle_pct = 46; end
                1:       begin tx_idle_pct = 46; rx_idle_pct = 14; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            drain_verdicts();
            random_setup();
            words     = 0;
            since_cfg = 0;
            while (words < RANDOM_WORDS / 3) begin
                if (since_cfg >= CFG_SPAN) begin
                    drain_verdicts();
                    random_setup();
                    since_cfg = 0;
                end
                pick = $urandom_range(99);
                if (!m_active) begin
                    if (pick < 75) begin
                        target = 2'($urandom_range(2));
                        send_word(CMD_START, 8'($urandom_range(255)));
                        words++;
                        since_cfg++;
                    end else begin
                        // ignored while closed, does not count
                        send_word(2'($urandom_range(1, 3)), 8'($urandom_range(255)));
                    end
                end else begin
                    if (pick < 3) begin
                        target = 2'($urandom_range(2));
                        send_word(CMD_START, 8'($urandom_range(255)));
                    end else if (pick < 5) begin
                        send_word(CMD_UNUSED, 8'($urandom_range(255)));
                    end else if (pick < 15) begin
                        send_word(CMD_TICK, 8'($urandom_range(255)));
                    end else begin
                        if (pick < 85 && target == 2'd0) begin
                            rx = char_at(m_pass_pat, match_pos(m_pass_cnt, m_pass_len));
                        end else if (pick < 85 && target == 2'd1) begin
                            rx = char_at(m_fail_pat, match_pos(m_fail_cnt, m_fail_len));
                        end else begin
                            rx = 8'($urandom_range(255));
                        end
                        send_word(CMD_BYTE, rx);
                    end
                    words++;
                    since_cfg++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_cmd        = CMD_START;
        i_rx_byte    = '0;
        i_cfg_we     = 1'b0;
        i_cfg_addr   = REG_PASS_PATTERN;
        i_cfg_data   = '0;
        hold_req     = 1'b0;
        err_count    = 0;
        quiet_cycles = 0;
        tx_idle_pct  = 14;
        rx_idle_pct  = 46;

        m_pass_pat = RST_PASS_PATTERN;
        m_pass_len = RST_PASS_LENGTH;
        m_fail_pat = RST_FAIL_PATTERN;
        m_fail_len = RST_FAIL_LENGTH;
        m_fail_en  = RST_FAIL_ENABLE;
        m_limit    = RST_TIMEOUT_LIMIT;
        m_active   = 1'b0;
        m_pass_cnt = '0;
        m_fail_cnt = '0;
        m_ticks    = '0;

        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_idle_until_start();
        test_fail_string();
        test_zero_timeout();
        test_pass_priority();
        test_length_lowered();
        test_limit_lowered();
        test_output_backpressure();
        test_random_traffic();

        drain_verdicts();
        if (err_count == 0 && verdict_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
